// ----- hdl/fvc_pkg.sv -----
`timescale 1ns / 1ps
// fvc_pkg: shared types, codes and constants of the frustum visibility classifier
// depends on nothing
package fvc_pkg;

	localparam int NumStages = 19;
	localparam int DivBits   = 14;
	localparam int DivFirst  = 5;

	typedef enum logic [1:0] {
		CLS_CULLED = 2'd0,
		CLS_FRONT  = 2'd1,
		CLS_BEHIND = 2'd2,
		CLS_EDGE   = 2'd3
	} vis_class_t;

	typedef enum logic [2:0] {
		REG_ORIGIN  = 3'd0,
		REG_FORWARD = 3'd1,
		REG_RIGHT   = 3'd2,
		REG_UP      = 3'd3,
		REG_HFOV    = 3'd4,
		REG_VFOV    = 3'd5,
		REG_VALID   = 3'd6
	} cfg_reg_t;

	localparam logic [11:0] FovMin   = 12'd320;
	localparam logic [11:0] FovMax   = 12'd2720;
	localparam logic [3:0]  TanLast  = 4'd15;
	localparam logic [11:0] Recip160 = 12'd3277;
	localparam logic [21:0] Recip160Wide = 22'd3355444;
	localparam logic [35:0] NearKeepSq = 36'd25600;
	localparam logic [22:0] RadiusNum = 23'd262144;

	localparam logic [15:0] TanHalf [16] = '{
		16'd722,   16'd1098,  16'd1491,  16'd1910,
		16'd2365,  16'd2868,  16'd3437,  16'd4096,
		16'd4881,  16'd5850,  16'd7094,  16'd8784,
		16'd11254, 16'd15286, 16'd23230, 16'd46817
	};

	typedef struct packed {
		logic [2:0][20:0] d;
		logic             crit;
		logic             inval;
		logic [8:0][36:0] prod;
		logic [2:0][38:0] sum;
		logic [23:0]      vf;
		logic [23:0]      vr;
		logic [23:0]      vu;
		logic [23:0]      ar;
		logic [23:0]      au;
		logic [38:0]      px;
		logic [38:0]      py;
		logic [30:0]      ar100;
		logic [30:0]      au100;
		logic [45:0]      px82;
		logic [45:0]      py82;
		logic             outside;
		logic             adm;
		vis_class_t       cls;
		logic             radok;
		logic [22:0]      rem;
		logic [22:0]      den;
		logic [DivBits-1:0] quo;
	} item_t;

	function automatic logic [23:0] sat_view(input logic [38:0] s);
		logic signed [38:0] t;
		t = ($signed(s) + 39'sd8192) >>> 14;
		if (t > 39'sd8388607)
			return 24'h7fffff;
		else if (t < -39'sd8388608)
			return 24'h800000;
		else
			return t[23:0];
	endfunction

endpackage

// ----- hdl/frustum_visibility_classifier.sv -----
`timescale 1ns / 1ps
// frustum_visibility_classifier: pipelined view projection, frustum test and radius divide
// depends on fvc_pkg
//
// channel  dir  fields (lowest bit first)
// s_axis   in   pos_x, pos_y, pos_z, range_squared, priority_level, has_effects
// m_axis   out  admitted, vis_class, fwd_dist, right_dist, up_dist, radius
// cfg      in   cfg_addr selects register, cfg_wdata holds the value
//
// one transaction per cycle through 19 register stages unless m_tready holds the output:
// stages 0 to 6 project, bound and classify, stages 5 to 18 resolve one radius
// quotient bit each
// arst_n clears valid bits and configuration; tangents settle through tidx_q, tprod_q and tan_q after a write
// each stage holds only while it is full and the stage after it is held
module frustum_visibility_classifier (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // pos_x, pos_y, pos_z, range_squared, priority_level, has_effects
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // admitted, vis_class, fwd_dist, right_dist, up_dist, radius
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [59:0]  cfg_wdata
);
	import fvc_pkg::*;

	logic [59:0] origin_q;
	logic [2:0][15:0] axis_q [3];
	logic [1:0][11:0] fov_q;
	logic        valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= '0;
			fov_q <= '0;
			valid_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ORIGIN:  origin_q  <= cfg_wdata;
				REG_FORWARD: axis_q[0] <= cfg_wdata[47:0];
				REG_RIGHT:   axis_q[1] <= cfg_wdata[47:0];
				REG_UP:      axis_q[2] <= cfg_wdata[47:0];
				REG_HFOV:    fov_q[0]  <= cfg_wdata[11:0];
				REG_VFOV:    fov_q[1]  <= cfg_wdata[11:0];
				REG_VALID:   valid_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// half field of view tangents, x then y
	logic [3:0]  tidx_q [2];
	logic [7:0]  trem_q [2];
	logic [15:0] tlo_q [2];
	logic [21:0] tprod_q [2];
	logic        tlast_q [2];
	logic [15:0] tan_q [2];

	for (genvar g = 0; g < 2; g++) begin : g_tan
		logic [11:0] f;
		logic [11:0] t;
		logic [23:0] ti;
		logic [3:0]  i;
		logic [3:0]  inext;
		logic [15:0] hi;
		logic [43:0] q;

		always_comb begin
			f = fov_q[g];
			if (f < FovMin)
				f = FovMin;
			else if (f > FovMax)
				f = FovMax;
			t = f - FovMin;
			ti = t * Recip160;
			i = ti[22:19];
			inext = (tidx_q[g] == TanLast) ? TanLast : tidx_q[g] + 4'd1;
			hi = TanHalf[inext];
			q = tprod_q[g] * Recip160Wide;
		end

		always_ff @(posedge clk) begin
			tidx_q[g] <= i;
			trem_q[g] <= 8'(t - 12'(i) * 12'd160);
			tlo_q[g] <= TanHalf[tidx_q[g]];
			tlast_q[g] <= (tidx_q[g] == TanLast);
			tprod_q[g] <= 22'(hi - TanHalf[tidx_q[g]]) * 22'(trem_q[g]) + 22'd80;
			tan_q[g] <= tlast_q[g] ? TanHalf[TanLast] : tlo_q[g] + 16'(q[43:29]);
		end
	end

	item_t pipe_s [NumStages];
	item_t nx [NumStages];
	logic [NumStages-1:0] vld_s;
	logic [NumStages:0]   en;

	always_comb begin
		en[NumStages] = m_tready;
		for (int k = NumStages - 1; k >= 0; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0])
				vld_s[0] <= s_tvalid;
			for (int k = 1; k < NumStages; k++) begin
				if (en[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NumStages; k++) begin
			if (en[k])
				pipe_s[k] <= nx[k];
		end
	end

	// offset from camera, critical test and invalid camera test
	always_comb begin
		nx[0] = '0;
		for (int c = 0; c < 3; c++)
			nx[0].d[c] = {s_tdata[20*c+19], s_tdata[20*c +: 20]} -
				{origin_q[20*c+19], origin_q[20*c +: 20]};
		nx[0].crit = (s_tdata[103:96] >= 8'd3) || s_tdata[104] ||
			(s_tdata[95:60] <= NearKeepSq);
		nx[0].inval = !valid_q || (fov_q[0] == 12'd0) || (fov_q[1] == 12'd0);
	end

	// axis products
	always_comb begin
		nx[1] = pipe_s[0];
		for (int a = 0; a < 3; a++)
			for (int c = 0; c < 3; c++)
				nx[1].prod[3*a+c] = $signed(pipe_s[0].d[c]) * $signed(axis_q[a][c]);
	end

	// dot product sums
	always_comb begin
		nx[2] = pipe_s[1];
		for (int a = 0; a < 3; a++)
			nx[2].sum[a] = 39'($signed(pipe_s[1].prod[3*a])) +
				39'($signed(pipe_s[1].prod[3*a+1])) +
				39'($signed(pipe_s[1].prod[3*a+2]));
	end

	// round and saturate view values
	always_comb begin
		nx[3] = pipe_s[2];
		nx[3].vf = sat_view(pipe_s[2].sum[0]);
		nx[3].vr = sat_view(pipe_s[2].sum[1]);
		nx[3].vu = sat_view(pipe_s[2].sum[2]);
	end

	// magnitudes, frustum bounds and divider setup
	always_comb begin
		nx[4] = pipe_s[3];
		nx[4].ar = pipe_s[3].vr[23] ? 24'(-pipe_s[3].vr) : pipe_s[3].vr;
		nx[4].au = pipe_s[3].vu[23] ? 24'(-pipe_s[3].vu) : pipe_s[3].vu;
		nx[4].px = pipe_s[3].vf[22:0] * tan_q[0];
		nx[4].py = pipe_s[3].vf[22:0] * tan_q[1];
		nx[4].den = pipe_s[3].vf[22:0];
		nx[4].rem = RadiusNum + 23'(pipe_s[3].vf[22:1]);
		nx[4].quo = '0;
	end

	item_t dv [NumStages];

	for (genvar k = DivFirst; k < NumStages; k++) begin : g_div
		localparam int B = NumStages - 1 - k;
		logic [36:0] dsh;

		always_comb begin
			dv[k] = pipe_s[k-1];
			dsh = {14'b0, pipe_s[k-1].den} << B;
			if ({14'b0, pipe_s[k-1].rem} >= dsh) begin
				dv[k].rem = pipe_s[k-1].rem - dsh[22:0];
				dv[k].quo[B] = 1'b1;
			end
		end

		if (k > DivFirst + 1) begin : g_plain
			assign nx[k] = dv[k];
		end
	end

	for (genvar k = 0; k < DivFirst; k++) begin : g_nodiv
		assign dv[k] = '0;
	end

	// outer bound test and edge scaling
	always_comb begin
		nx[DivFirst] = dv[DivFirst];
		nx[DivFirst].ar100 = pipe_s[4].ar * 7'd100;
		nx[DivFirst].au100 = pipe_s[4].au * 7'd100;
		nx[DivFirst].px82 = pipe_s[4].px * 7'd82;
		nx[DivFirst].py82 = pipe_s[4].py * 7'd82;
		nx[DivFirst].outside =
			({4'b0, pipe_s[4].ar, 12'b0} > {1'b0, pipe_s[4].px} + 40'(96 << 16)) ||
			({4'b0, pipe_s[4].au, 12'b0} > {1'b0, pipe_s[4].py} + 40'(96 << 16));
	end

	// classification
	always_comb begin
		logic edge_hit;
		logic signed [23:0] vf;
		nx[DivFirst+1] = dv[DivFirst+1];
		vf = $signed(pipe_s[DivFirst].vf);
		edge_hit = ({3'b0, pipe_s[DivFirst].ar100, 12'b0} > pipe_s[DivFirst].px82) ||
			({3'b0, pipe_s[DivFirst].au100, 12'b0} > pipe_s[DivFirst].py82);
		nx[DivFirst+1].radok = 1'b0;
		if (pipe_s[DivFirst].crit) begin
			nx[DivFirst+1].adm = 1'b1;
			nx[DivFirst+1].cls = vf[23] ? CLS_BEHIND : CLS_FRONT;
		end else if (pipe_s[DivFirst].inval) begin
			nx[DivFirst+1].adm = 1'b1;
			nx[DivFirst+1].cls = CLS_FRONT;
		end else if (vf <= -24'sd2048) begin
			nx[DivFirst+1].adm = 1'b0;
			nx[DivFirst+1].cls = CLS_CULLED;
		end else if (vf <= 24'sd16) begin
			nx[DivFirst+1].adm = 1'b1;
			nx[DivFirst+1].cls = CLS_BEHIND;
		end else if (pipe_s[DivFirst].outside) begin
			nx[DivFirst+1].adm = 1'b0;
			nx[DivFirst+1].cls = CLS_CULLED;
		end else begin
			nx[DivFirst+1].adm = 1'b1;
			nx[DivFirst+1].cls = edge_hit ? CLS_EDGE : CLS_FRONT;
			nx[DivFirst+1].radok = 1'b1;
		end
	end

	item_t last;
	assign last = pipe_s[NumStages-1];
	assign m_tvalid = vld_s[NumStages-1];
	assign m_tdata = {6'b0, last.radok ? {1'b0, last.quo} : 15'd0,
		last.vu, last.vr, last.vf, last.cls, last.adm};

	a_radius_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[89:75] != 15'd0) |->
			(m_tdata[2:1] == CLS_FRONT) || (m_tdata[2:1] == CLS_EDGE))
		else $error("radius on a result that is not front or edge");

	a_admit_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != CLS_CULLED)))
		else $error("admitted flag disagrees with class");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_s) && !m_tready)
		else $error("input held while the pipeline has room");

endmodule

// ----- tb/sv/fvc_checker.sv -----
`timescale 1ns / 1ps
// fvc_checker: watches the input, output and configuration ports of the frustum classifier,
// predicts each result from its own copy of the registers and compares it; depends on fvc_pkg
module fvc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [59:0]  cfg_wdata,
	output int           fails,
	output int           pending
);
	import fvc_pkg::*;

	typedef struct {
		bit         adm;
		vis_class_t cls;
		longint     vf;
		longint     vr;
		longint     vu;
		longint     rad;
	} verdict_t;

	localparam int HalfTanQ12 [16] = '{
		722, 1098, 1491, 1910, 2365, 2868, 3437, 4096,
		4881, 5850, 7094, 8784, 11254, 15286, 23230, 46817
	};

	logic [59:0] cam_origin;
	logic [47:0] ax_fwd, ax_right, ax_up;
	logic [11:0] fov_h, fov_v;
	logic        basis_ok;
	verdict_t    verdict_q[$];

	function automatic longint project_axis(input longint off[3], input logic [47:0] ax);
		longint s, t;
		s = 0;
		for (int k = 0; k < 3; k++)
			s += off[k] * longint'($signed(ax[16*k +: 16]));
		t = (s + 8192) >>> 14;
		if (t > 8388607) t = 8388607;
		if (t < -8388608) t = -8388608;
		return t;
	endfunction

	function automatic longint half_tangent(input logic [11:0] fov);
		int f, t, i, r;
		f = fov;
		if (f < 320) f = 320;
		if (f > 2720) f = 2720;
		t = f - 320;
		i = t / 160;
		r = t % 160;
		if (i >= 15)
			return HalfTanQ12[15];
		return HalfTanQ12[i] + ((HalfTanQ12[i+1] - HalfTanQ12[i]) * r + 80) / 160;
	endfunction

	function automatic verdict_t classify(input logic [111:0] d);
		verdict_t v;
		longint off[3];
		longint tx, ty, px, py, ar, au;
		bit crit;
		for (int k = 0; k < 3; k++)
			off[k] = longint'($signed(d[20*k +: 20])) - longint'($signed(cam_origin[20*k +: 20]));
		v.vf = project_axis(off, ax_fwd);
		v.vr = project_axis(off, ax_right);
		v.vu = project_axis(off, ax_up);
		v.adm = 0;
		v.cls = CLS_CULLED;
		v.rad = 0;
		crit = d[103:96] >= 3 || d[104] || d[95:60] <= 36'd25600;
		if (crit) begin
			v.adm = 1;
			v.cls = v.vf >= 0 ? CLS_FRONT : CLS_BEHIND;
		end else if (!basis_ok || fov_h == 0 || fov_v == 0) begin
			v.adm = 1;
			v.cls = CLS_FRONT;
		end else if (v.vf <= -2048) begin
			v.cls = CLS_CULLED;
		end else if (v.vf <= 16) begin
			v.adm = 1;
			v.cls = CLS_BEHIND;
		end else begin
			tx = half_tangent(fov_h);
			ty = half_tangent(fov_v);
			ar = v.vr < 0 ? -v.vr : v.vr;
			au = v.vu < 0 ? -v.vu : v.vu;
			px = v.vf * tx;
			py = v.vf * ty;
			if (ar * 4096 > px + (64'sd96 <<< 16) || au * 4096 > py + (64'sd96 <<< 16)) begin
				v.cls = CLS_CULLED;
			end else begin
				v.adm = 1;
				v.cls = (ar * 409600 > px * 82 || au * 409600 > py * 82) ? CLS_EDGE : CLS_FRONT;
				v.rad = (262144 + v.vf / 2) / v.vf;
			end
		end
		return v;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t e;
		if (!arst_n) begin
			cam_origin = '0;
			ax_fwd = '0;
			ax_right = '0;
			ax_up = '0;
			fov_h = '0;
			fov_v = '0;
			basis_ok = 0;
			verdict_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_ORIGIN: cam_origin = cfg_wdata;
					REG_FORWARD: ax_fwd = cfg_wdata[47:0];
					REG_RIGHT: ax_right = cfg_wdata[47:0];
					REG_UP: ax_up = cfg_wdata[47:0];
					REG_HFOV: fov_h = cfg_wdata[11:0];
					REG_VFOV: fov_v = cfg_wdata[11:0];
					REG_VALID: basis_ok = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				verdict_q.push_back(classify(s_tdata));
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$display("unexpected result transaction at %0t", $realtime);
					fails++;
				end else begin
					e = verdict_q.pop_front();
					if (m_tdata[0] !== e.adm) report("admitted", m_tdata[0], e.adm);
					if (m_tdata[2:1] !== e.cls) report("vis_class", m_tdata[2:1], e.cls);
					if (m_tdata[26:3] !== e.vf[23:0])
						report("fwd_dist", $signed(m_tdata[26:3]), e.vf);
					if (m_tdata[50:27] !== e.vr[23:0])
						report("right_dist", $signed(m_tdata[50:27]), e.vr);
					if (m_tdata[74:51] !== e.vu[23:0])
						report("up_dist", $signed(m_tdata[74:51]), e.vu);
					if (m_tdata[89:75] !== e.rad[14:0])
						report("radius", m_tdata[89:75], e.rad);
				end
			end
		end
		pending = verdict_q.size();
	end

	initial begin
		fails = 0;
		pending = 0;
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: drives entities and camera settings into the frustum classifier with bursty input
// and a stalling output side; depends on fvc_pkg, frustum_visibility_classifier, fvc_checker
module tb;
	import fvc_pkg::*;

	localparam longint CycleLimit = 600000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [59:0]  cfg_wdata;
	int           fails;
	int           pending;
	longint       cycles;
	int           burst_left;
	int           stall_mode;
	int           stall_count;
	logic [59:0]  origin_now;

	frustum_visibility_classifier uut (.*);

	fvc_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[frustum_visibility_classifier] ERROR");
			$finish;
		end
	end

	// output side: stall pattern changes every so often
	always @(negedge clk) begin
		if (stall_count == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_count = $urandom_range(20, 200);
		end
		stall_count--;
		case (stall_mode)
			0: m_tready = 1;
			1: m_tready = $urandom_range(0, 1);
			2: m_tready = cycles[2];
			default: m_tready = $urandom_range(0, 7) != 0;
		endcase
	end

	function automatic logic [111:0] entity(input logic [19:0] x, input logic [19:0] y,
			input logic [19:0] z, input logic [35:0] rsq, input logic [7:0] prio,
			input logic fx);
		return {7'b0, fx, prio, rsq, z, y, x};
	endfunction

	task automatic send(input logic [111:0] d);
		s_tdata = d;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (pending != 0) @(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [59:0] val);
		cfg_addr = idx;
		cfg_wdata = val;
		cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
		if (idx == REG_ORIGIN) origin_now = val;
	endtask

	task automatic set_camera(input logic [59:0] org, input logic [47:0] f, input logic [47:0] r,
			input logic [47:0] u, input logic [11:0] h, input logic [11:0] v, input logic ok);
		drain();
		write_reg(REG_ORIGIN, org);
		write_reg(REG_FORWARD, {12'b0, f});
		write_reg(REG_RIGHT, {12'b0, r});
		write_reg(REG_UP, {12'b0, u});
		write_reg(REG_HFOV, {48'b0, h});
		write_reg(REG_VFOV, {48'b0, v});
		write_reg(REG_VALID, {59'b0, ok});
		repeat (5) @(negedge clk);
	endtask

	function automatic logic [19:0] near_coord(input int k, input int span);
		return origin_now[20*k +: 20] + 20'($signed($urandom_range(0, 2*span)) - span);
	endfunction

	task automatic random_items(input int n);
		logic [19:0] c[3];
		logic [35:0] rsq;
		logic [7:0]  prio;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			for (int k = 0; k < 3; k++)
				c[k] = sel == 0 ? 20'($urandom) : near_coord(k, sel < 5 ? 4000 : 60000);
			rsq = $urandom_range(0, 9) == 0 ? 36'($urandom_range(0, 30000))
				: {4'($urandom), 32'($urandom)} | 36'd25601;
			prio = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
			send(entity(c[0], c[1], c[2], rsq, prio, $urandom_range(0, 15) == 0));
		end
	endtask

	localparam logic [47:0] AxX = 48'h0000_0000_4000;
	localparam logic [47:0] AxY = 48'h0000_4000_0000;
	localparam logic [47:0] AxZ = 48'h4000_0000_0000;
	localparam logic [35:0] Far = 36'd1000000;

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cycles = 0;
		burst_left = 10;
		stall_count = 0;
		origin_now = '0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		repeat (3) @(negedge clk);

		// registers at reset: camera invalid
		send(entity(20'h80000, 20'h80000, 20'h80000, 36'd0, 8'd0, 1'b0));
		send(entity(20'h7ffff, 20'h7ffff, 20'h7ffff, 36'hfffffffff, 8'd255, 1'b1));
		send(entity(20'd100, 20'd0, 20'd1600, Far, 8'd0, 1'b0));

		set_camera(60'd0, AxZ, AxX, AxY, 12'd1440, 12'd960, 1'b1);
		send(entity(20'd0, 20'd0, 20'd1600, Far, 8'd0, 1'b0));
		send(entity(20'd1500, 20'd0, 20'd1600, Far, 8'd0, 1'b0));
		send(entity(20'd3000, 20'd0, 20'd1600, Far, 8'd1, 1'b0));
		send(entity(20'd0, -20'sd1400, 20'd1600, Far, 8'd2, 1'b0));
		send(entity(20'd0, 20'd0, -20'sd4000, Far, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, -20'sd2048, Far, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, -20'sd2047, Far, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, 20'd16, Far, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, 20'd17, Far, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, 20'h7ffff, Far, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, -20'sd500, Far, 8'd3, 1'b0));
		send(entity(20'd0, 20'd0, -20'sd500, Far, 8'd0, 1'b1));
		send(entity(20'd0, 20'd0, -20'sd500, 36'd25600, 8'd0, 1'b0));
		send(entity(20'd0, 20'd0, -20'sd500, 36'd25601, 8'd0, 1'b0));
		send(entity(20'h80000, 20'h80000, 20'h7ffff, 36'hfffffffff, 8'd0, 1'b0));

		set_camera({20'h7ffff, 20'h80000, 20'h7ffff}, 48'h8000_8000_8000,
			48'h7fff_7fff_7fff, 48'hffff_ffff_ffff, 12'd4095, 12'd1, 1'b1);
		send(entity(20'h80000, 20'h7ffff, 20'h80000, Far, 8'd0, 1'b0));
		send(entity(20'h7ffff, 20'h80000, 20'h7ffff, Far, 8'd0, 1'b0));
		random_items(120);

		set_camera(60'd0, AxZ, AxX, AxY, 12'd0, 12'd960, 1'b1);
		random_items(80);
		set_camera(60'd0, AxZ, AxX, AxY, 12'd1440, 12'd0, 1'b1);
		random_items(80);
		set_camera(60'd0, AxZ, AxX, AxY, 12'd1440, 12'd960, 1'b0);
		random_items(80);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: set_camera({20'($urandom), 20'($urandom), 20'($urandom)}, AxX, AxY, AxZ,
					12'($urandom_range(320, 2720)), 12'($urandom_range(320, 2720)), 1'b1);
				1: set_camera({20'($urandom_range(0, 5000)), 20'd0, 20'd0}, -48'sh4000_0000_0000,
					AxX, AxY, 12'd320, 12'd2720, 1'b1);
				2: set_camera({4'($urandom), 28'($urandom), 28'($urandom)},
					{16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
					{16'($urandom), 32'($urandom)}, 12'($urandom), 12'($urandom), 1'b1);
				default: set_camera(60'd0, {16'd11585, 16'd0, 16'd11585},
					{-16'sd11585, 16'd0, 16'd11585}, AxY,
					12'($urandom_range(1, 4095)), 12'($urandom_range(300, 2800)), 1'b1);
			endcase
			random_items(150);
		end

		drain();
		if (fails == 0)
			$display("[frustum_visibility_classifier] OK");
		else
			$display("[frustum_visibility_classifier] ERROR");
		$finish;
	end

endmodule
